### hw/rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// clocked assertion, checked through reset too
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### hw/rtl/lfra_pkg.sv
`default_nettype none

package lfra_pkg;

    localparam int DEF_CUSTOMERS = 1024;
    localparam int DEF_ROOMS     = 256;

    localparam int CUST_W = 10;
    localparam int ROOM_W = 9;
    localparam int PEAK_W = 9;
    localparam int ERR_W  = 2;

    // free map scan window
    localparam int SCAN_W   = 16;
    localparam int SCAN_LOG = 4;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_ROOM  = 2'd1,
        ERR_NOT_HELD = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic scan_clr;
        logic scan_next;
        logic set_en;
        logic take_en;
    } t_fm_ctrl;

    typedef struct packed {
        logic hit;
        logic last;
    } t_fm_stat;

endpackage

`default_nettype wire

### hw/rtl/lfra_free_map.sv
`default_nettype none

module lfra_free_map
    import lfra_pkg::*;
#(
    parameter int ROOMS = DEF_ROOMS,
    localparam int IW = $clog2(ROOMS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_fm_ctrl      i_ctrl,
    input  wire logic [IW-1:0] i_set_idx,
    output t_fm_stat           o_stat,
    output logic [IW-1:0]      o_idx
);

    localparam int NCH = (ROOMS + SCAN_W - 1) / SCAN_W;
    localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int MW  = NCH * SCAN_W;

    logic [MW-1:0]       r_map;
    logic [CIW-1:0]      r_chunk;
    logic [SCAN_W-1:0]   chunk_bits;
    logic [SCAN_LOG-1:0] pe;

    assign chunk_bits = r_map[{r_chunk, {SCAN_LOG{1'b0}}} +: SCAN_W];

    // lowest set bit of the current window
    always_comb begin
        pe = '0;
        for (int i = SCAN_W - 1; i >= 0; i--) begin
            if (chunk_bits[i]) begin
                pe = SCAN_LOG'(i);
            end
        end
    end

    assign o_idx       = IW'({r_chunk, pe});
    assign o_stat.hit  = |chunk_bits;
    assign o_stat.last = (r_chunk == CIW'(NCH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_chunk <= '0;
        end else begin
            if (i_ctrl.set_en) begin
                r_map[i_set_idx] <= 1'b1;
            end
            if (i_ctrl.take_en) begin
                r_map[o_idx] <= 1'b0;
            end
            if (i_ctrl.scan_clr) begin
                r_chunk <= '0;
            end else if (i_ctrl.scan_next) begin
                r_chunk <= r_chunk + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lowest_free_room_allocator_core.sv
// Room allocator for time-ordered arrival and departure events. After reset the block
// clears its customer table, one entry per cycle, and holds busy high meanwhile. An
// event is taken when start is high and busy is low; its result shows on o_valid for
// exactly one cycle and must be captured then, since the receiver cannot hold it off.
// A departure, a repeated arrival or an out-of-range customer is decided in the
// evaluate state, and its result is registered from there. An arrival that needs a
// room goes on to the scan state: the free-room map is scanned 16 rooms per cycle by a
// single priority encoder until the lowest free room is found or the map is exhausted.
// busy drops in the cycle that shows the result, so a new event may be taken then.
`default_nettype none

module lowest_free_room_allocator_core
    import lfra_pkg::*;
#(
    parameter int CUSTOMERS = DEF_CUSTOMERS,
    parameter int ROOMS     = DEF_ROOMS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_mode,
    input  wire logic [CUST_W-1:0] i_customer,
    output logic                   o_valid,
    output logic [ROOM_W-1:0]      o_room,
    output logic [PEAK_W-1:0]      o_peak_rooms,
    output logic [ERR_W-1:0]       o_error
);

    localparam int AW = $clog2(CUSTOMERS);
    localparam int RW = $clog2(ROOMS + 1);
    localparam int IW = $clog2(ROOMS);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic            r_mode;
    logic [AW-1:0]   r_addr;
    logic            r_in_range;
    logic [RW-1:0]   r_rd_data;
    logic [RW-1:0]   r_created, n_created;
    logic [RW-1:0]   r_occ, n_occ;
    logic [RW-1:0]   r_peak, n_peak;
    logic            r_out_valid, n_out_valid;
    logic [ROOM_W-1:0] r_out_room, n_out_room;
    logic [PEAK_W-1:0] r_out_peak, n_out_peak;
    t_err            r_out_error, n_out_error;

    logic [RW-1:0]   mem [CUSTOMERS];
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [RW-1:0]   mem_wd;

    logic            accept;
    logic [16:0]     cust_ext;
    logic            cust_in_range;

    t_fm_ctrl        fm_ctrl;
    t_fm_stat        fm_stat;
    logic [IW-1:0]   fm_set_idx;
    logic [IW-1:0]   fm_idx;
    logic [RW-1:0]   room;

    assign busy          = (r_state != ST_IDLE);
    assign accept        = start && !busy;
    assign cust_ext      = 17'(i_customer);
    assign cust_in_range = (cust_ext < 17'(CUSTOMERS));

    lfra_free_map #(
        .ROOMS (ROOMS)
    ) u_free_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (fm_ctrl),
        .i_set_idx (fm_set_idx),
        .o_stat    (fm_stat),
        .o_idx     (fm_idx)
    );

    // customer table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd_data <= mem[cust_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_created   <= '0;
            r_occ       <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_created   <= n_created;
            r_occ       <= n_occ;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode     <= i_mode;
            r_addr     <= cust_ext[AW-1:0];
            r_in_range <= cust_in_range;
        end
        r_out_room  <= n_out_room;
        r_out_peak  <= n_out_peak;
        r_out_error <= n_out_error;
    end

    always_comb begin
        n_state     = r_state;
        n_created   = r_created;
        n_occ       = r_occ;
        n_peak      = r_peak;
        n_out_valid = 1'b0;
        n_out_room  = r_out_room;
        n_out_peak  = r_out_peak;
        n_out_error = r_out_error;
        mem_we      = 1'b0;
        mem_wa      = r_addr;
        mem_wd      = '0;
        fm_ctrl     = '0;
        fm_set_idx  = IW'(r_rd_data - RW'(1));
        room        = '0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                if (r_clr_addr == AW'(CUSTOMERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_mode) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_peak  = PEAK_W'(r_peak);
                    if (!r_in_range || r_rd_data == '0) begin
                        n_out_room  = '0;
                        n_out_error = ERR_NOT_HELD;
                    end else begin
                        mem_we         = 1'b1;
                        fm_ctrl.set_en = 1'b1;
                        if (r_occ != '0) begin
                            n_occ = r_occ - 1'b1;
                        end
                        n_out_room  = ROOM_W'(r_rd_data);
                        n_out_error = ERR_OK;
                    end
                end else if (!r_in_range) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_peak  = PEAK_W'(r_peak);
                    n_out_room  = '0;
                    n_out_error = ERR_NO_ROOM;
                end else if (r_rd_data != '0) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_peak  = PEAK_W'(r_peak);
                    n_out_room  = ROOM_W'(r_rd_data);
                    n_out_error = ERR_OK;
                end else begin
                    fm_ctrl.scan_clr = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (fm_stat.hit) begin
                    fm_ctrl.take_en = 1'b1;
                    room            = RW'(fm_idx) + RW'(1);
                end else if (fm_stat.last) begin
                    if (r_created < RW'(ROOMS)) begin
                        room      = r_created + RW'(1);
                        n_created = room;
                    end
                end else begin
                    fm_ctrl.scan_next = 1'b1;
                end

                if (fm_stat.hit || fm_stat.last) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (room != '0) begin
                        mem_we = 1'b1;
                        mem_wd = room;
                        n_occ  = r_occ + 1'b1;
                        if (n_occ > r_peak) begin
                            n_peak = n_occ;
                        end
                        n_out_error = ERR_OK;
                    end else begin
                        n_out_error = ERR_NO_ROOM;
                    end
                    n_out_room = ROOM_W'(room);
                    n_out_peak = PEAK_W'(n_peak);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_room       = r_out_room;
    assign o_peak_rooms = r_out_peak;
    assign o_error      = r_out_error;

endmodule

`default_nettype wire

### hw/rtl/lfra_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lfra_checker
    import lfra_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              i_mode,
    input wire logic [CUST_W-1:0] i_customer,
    input wire logic              o_valid,
    input wire logic [ROOM_W-1:0] o_room,
    input wire logic [PEAK_W-1:0] o_peak_rooms,
    input wire logic [ERR_W-1:0]  o_error
);

    logic unused_payload;
    assign unused_payload = ^{i_mode, i_customer, o_peak_rooms};

    // a transfer always starts work
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    // result appears as the block frees up, after working
    `ASSERT_CLK(a_valid_idle, i_clk, i_rst_n, o_valid |-> (!busy && $past(busy)))
    // one strobe per item
    `ASSERT_CLK(a_valid_single, i_clk, i_rst_n, o_valid |=> !o_valid)
    // failed events report no room
    `ASSERT_CLK(a_err_room, i_clk, i_rst_n, (o_valid && o_error != ERR_OK) |-> (o_room == '0))

endmodule

bind lowest_free_room_allocator_core lfra_checker u_lfra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_mode       (i_mode),
    .i_customer   (i_customer),
    .o_valid      (o_valid),
    .o_room       (o_room),
    .o_peak_rooms (o_peak_rooms),
    .o_error      (o_error)
);

`default_nettype wire

### tb/lowest_free_room_allocator_core_test.sv
`timescale 1ns / 1ps

module lowest_free_room_allocator_core_test;
    import lfra_pkg::*;

    localparam int  ROOMS       = DEF_ROOMS;
    localparam int  CUSTOMERS   = DEF_CUSTOMERS;
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_DEPART = 1'b1;
    localparam int  SETTLE_CYCLES = 40;

    typedef struct packed {
        logic              mode;
        logic [CUST_W-1:0] cust;
    } t_room_event;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [PEAK_W-1:0] peak;
        t_err              err;
    } t_booking;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              i_mode = 1'b0;
    logic [CUST_W-1:0] i_customer = '0;
    logic              busy;
    logic              o_valid;
    logic [ROOM_W-1:0] o_room;
    logic [PEAK_W-1:0] o_peak_rooms;
    logic [ERR_W-1:0]  o_error;

    t_room_event pending_events[$];
    t_booking    expected_bookings[$];
    t_booking    arrived;
    t_room_event next_event;
    bit          steady = 1'b0;
    int          failures = 0;

    // predicted block state
    logic [ROOM_W-1:0] room_held[CUSTOMERS];
    bit                vacant[ROOMS];
    int                rooms_opened = 0;
    int                in_use = 0;
    int                peak = 0;

    // stimulus bookkeeping of who holds a room
    bit guest_in[CUSTOMERS];
    int guests[$];

    lowest_free_room_allocator_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_customer   (i_customer),
        .o_valid      (o_valid),
        .o_room       (o_room),
        .o_peak_rooms (o_peak_rooms),
        .o_error      (o_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        foreach (room_held[k]) room_held[k] = '0;
        foreach (vacant[k]) vacant[k] = 1'b0;
        foreach (guest_in[k]) guest_in[k] = 1'b0;
    end

    function automatic t_booking book_room(logic mode, logic [CUST_W-1:0] cust);
        t_booking b;
        int slot;
        b.room = '0;
        b.err = ERR_OK;
        slot = -1;
        if (mode == MODE_ARRIVE) begin
            if (room_held[cust] != '0) begin
                b.room = room_held[cust];
            end else begin
                for (int k = ROOMS - 1; k >= 0; k--)
                    if (vacant[k]) slot = k;
                if (slot >= 0) begin
                    vacant[slot] = 1'b0;
                    b.room = ROOM_W'(slot + 1);
                end else if (rooms_opened < ROOMS) begin
                    rooms_opened++;
                    b.room = ROOM_W'(rooms_opened);
                end else begin
                    b.err = ERR_NO_ROOM;
                end
                if (b.err == ERR_OK) begin
                    room_held[cust] = b.room;
                    in_use++;
                end
            end
        end else begin
            if (room_held[cust] == '0) begin
                b.err = ERR_NOT_HELD;
            end else begin
                b.room = room_held[cust];
                vacant[b.room - 1] = 1'b1;
                room_held[cust] = '0;
                in_use--;
            end
        end
        if (in_use > peak) peak = in_use;
        b.peak = PEAK_W'(peak);
        return b;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_mode <= 1'b0;
            i_customer <= '0;
        end else begin
            if (start && !busy)
                expected_bookings.insert(expected_bookings.size(),
                                         book_room(i_mode, i_customer));
            if (!start || !busy) begin
                if (pending_events.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
                    next_event = pending_events.pop_front();
                    start <= 1'b1;
                    i_mode <= next_event.mode;
                    i_customer <= next_event.cust;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_bookings.size() == 0) begin
                $error("unexpected result: room %0d peak %0d error %0d",
                       o_room, o_peak_rooms, o_error);
                failures++;
            end else begin
                arrived = expected_bookings.pop_front();
                if (o_room !== arrived.room) begin
                    $error("room: expected %0d, got %0d", arrived.room, o_room);
                    failures++;
                end
                if (o_peak_rooms !== arrived.peak) begin
                    $error("peak_rooms: expected %0d, got %0d", arrived.peak, o_peak_rooms);
                    failures++;
                end
                if (o_error !== arrived.err) begin
                    $error("error: expected %0d, got %0d", arrived.err, o_error);
                    failures++;
                end
            end
        end
    end

    task automatic queue_event(logic mode, logic [CUST_W-1:0] cust);
        t_room_event ev;
        int pos;
        ev.mode = mode;
        ev.cust = cust;
        pending_events.insert(pending_events.size(), ev);
        pos = -1;
        if (mode == MODE_ARRIVE) begin
            if (!guest_in[cust] && guests.size() < ROOMS) begin
                guest_in[cust] = 1'b1;
                guests.insert(guests.size(), int'(cust));
            end
        end else if (guest_in[cust]) begin
            guest_in[cust] = 1'b0;
            foreach (guests[k])
                if (guests[k] == int'(cust)) pos = k;
            guests.delete(pos);
        end
    endtask

    task automatic run_phase(int count, int arrive_pct);
        logic [CUST_W-1:0] c;
        for (int n = 0; n < count; n++) begin
            while (pending_events.size() >= 8) @(posedge i_clk);
            if ($urandom_range(99) < 10) begin
                queue_event(1'($urandom_range(1)), CUST_W'($urandom));
            end else if ($urandom_range(99) < arrive_pct) begin
                if (guests.size() != 0 && $urandom_range(9) == 0)
                    c = CUST_W'(guests[$urandom_range(guests.size() - 1)]);
                else
                    c = CUST_W'($urandom);
                queue_event(MODE_ARRIVE, c);
            end else if (guests.size() != 0) begin
                queue_event(MODE_DEPART, CUST_W'(guests[$urandom_range(guests.size() - 1)]));
            end else begin
                queue_event(MODE_DEPART, CUST_W'($urandom));
            end
        end
    endtask

    task automatic drain;
        while (pending_events.size() != 0 || start || expected_bookings.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_event(MODE_ARRIVE, 10'd0);
        queue_event(MODE_ARRIVE, 10'd1023);
        queue_event(MODE_ARRIVE, 10'd0);
        queue_event(MODE_DEPART, 10'd5);
        queue_event(MODE_DEPART, 10'd0);
        queue_event(MODE_DEPART, 10'd0);
        queue_event(MODE_ARRIVE, 10'd512);
        queue_event(MODE_ARRIVE, 10'd0);
        queue_event(MODE_DEPART, 10'd1023);
        queue_event(MODE_DEPART, 10'd512);
        queue_event(MODE_ARRIVE, 10'd341);
        queue_event(MODE_ARRIVE, 10'd682);
        queue_event(MODE_ARRIVE, 10'd1023);
        drain();

        // fill every room, then hover near full
        run_phase(500, 90);
        steady = 1'b1;
        run_phase(500, 50);
        steady = 1'b0;
        drain();
        run_phase(450, 15);
        run_phase(500, 55);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_bookings.size() == 0)
            $display("[lowest_free_room_allocator_core] OK");
        else
            $display("[lowest_free_room_allocator_core] ERROR");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[lowest_free_room_allocator_core] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lfra_pkg.sv
hw/rtl/lfra_free_map.sv
hw/rtl/lowest_free_room_allocator_core.sv
hw/rtl/lfra_checker.sv
tb/lowest_free_room_allocator_core_test.sv
